### design/aaf_pkg.sv
`timescale 1ns / 1ps

package aaf_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_W       = 32;
  localparam int SUM_W        = 38;
  // value * count, both taken as signed
  localparam int PROD_W       = DATA_W + CNT_W + 1;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_NONE_ABOVE = 2'd1;
  localparam status_t ST_OVERFLOW   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // input transaction accepted
    logic scan;    // buffer walk in progress
    logic flush;   // emit closing result and clear the set
  } aaf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } aaf_stat_t;

endpackage

### design/aaf_ctrl.sv
`timescale 1ns / 1ps

module aaf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  aaf_pkg::aaf_stat_t stat,
  output aaf_pkg::aaf_cmd_t  cmd
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_LOAD);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.load  = accept;
    cmd.scan  = (state_r == S_SCAN);
    cmd.flush = (state_r == S_FLUSH) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept && in_tlast) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (stat.out_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/aaf_dp.sv
`timescale 1ns / 1ps

module aaf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  aaf_pkg::aaf_cmd_t                 cmd,
  output aaf_pkg::aaf_stat_t                stat,
  input  logic signed [aaf_pkg::DATA_W-1:0] sample,
  output logic signed [aaf_pkg::DATA_W-1:0] picked,
  output logic                              end_of_run,
  output aaf_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready
);

  logic [aaf_pkg::DATA_W-1:0] mem [aaf_pkg::MAX_ELEMENTS];

  logic signed [aaf_pkg::SUM_W-1:0]  sum_r;
  logic [aaf_pkg::CNT_W-1:0]         cnt_r;
  logic                              ovf_r;
  logic [aaf_pkg::CNT_W-1:0]         idx_r;

  logic                              v1_r;
  logic [aaf_pkg::DATA_W-1:0]        rdata_r;
  logic                              v2_r;
  logic [aaf_pkg::DATA_W-1:0]        val2_r;
  logic signed [aaf_pkg::PROD_W-1:0] prod_r;

  logic                              pend_v_r;
  logic [aaf_pkg::DATA_W-1:0]        pend_r;

  logic                              out_valid_r;
  logic [aaf_pkg::DATA_W-1:0]        out_data_r;
  logic                              out_last_r;
  aaf_pkg::status_t                  out_status_r;

  logic                              adv;
  logic                              room;
  logic                              issue;
  logic                              hit;
  logic                              take;
  logic signed [aaf_pkg::PROD_W-1:0] prod_nxt;
  logic signed [aaf_pkg::PROD_W-1:0] sum_ext;
  aaf_pkg::status_t                  ok_status;

  // whole scan pipeline stalls while a result sits untaken
  assign adv   = !out_valid_r || out_ready;
  assign room  = (cnt_r < aaf_pkg::CNT_W'(aaf_pkg::MAX_ELEMENTS));
  assign issue = cmd.scan && adv && (idx_r < cnt_r);

  assign prod_nxt = $signed({{(aaf_pkg::PROD_W - aaf_pkg::DATA_W){rdata_r[aaf_pkg::DATA_W-1]}},
                             rdata_r}) *
                    $signed(aaf_pkg::PROD_W'(cnt_r));
  assign sum_ext  = $signed({{(aaf_pkg::PROD_W - aaf_pkg::SUM_W){sum_r[aaf_pkg::SUM_W-1]}},
                             sum_r});
  assign hit      = prod_r > sum_ext;
  assign take     = cmd.scan && adv && v2_r && hit;

  assign ok_status = ovf_r ? aaf_pkg::ST_OVERFLOW : aaf_pkg::ST_OK;

  assign stat.scan_done = (idx_r == cnt_r) && !v1_r && !v2_r;
  assign stat.out_free  = adv;

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[cnt_r[aaf_pkg::IDX_W-1:0]] <= sample;
    end
    if (issue) begin
      rdata_r <= mem[idx_r[aaf_pkg::IDX_W-1:0]];
    end
  end

  // set accumulation and walk pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      idx_r <= '0;
    end else if (cmd.flush) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cmd.load) begin
        if (room) begin
          sum_r <= sum_r + {{(aaf_pkg::SUM_W - aaf_pkg::DATA_W){sample[aaf_pkg::DATA_W-1]}},
                            sample};
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (issue) idx_r <= idx_r + 1'b1;
    end
  end

  // read -> multiply pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      val2_r <= rdata_r;
    end
  end

  // one hit is held back so the final one can carry tlast
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.flush) begin
      pend_v_r <= 1'b0;
    end else if (take) begin
      pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) pend_r <= val2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.flush || (take && pend_v_r)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_last_r <= 1'b1;
      if (pend_v_r) begin
        out_data_r   <= pend_r;
        out_status_r <= ok_status;
      end else begin
        out_data_r   <= '0;
        out_status_r <= ovf_r ? aaf_pkg::ST_OVERFLOW : aaf_pkg::ST_NONE_ABOVE;
      end
    end else if (take && pend_v_r) begin
      out_data_r   <= pend_r;
      out_last_r   <= 1'b0;
      out_status_r <= ok_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign picked     = out_data_r;
  assign end_of_run = out_last_r;
  assign status     = out_status_r;

endmodule

### design/above_average_filter.sv
`timescale 1ns / 1ps

// Loads a set of signed 32-bit samples, one per cycle, up to 64 of them; the
// transaction with in_tlast set closes the set (samples past 64 are dropped and
// flag overflow). The block then stops taking input and walks its buffer once,
// one entry per cycle through a read/multiply pipeline, emitting in order every
// sample whose value times count exceeds the sum (strictly above the mean). The
// last result carries out_tlast. If nothing is above the mean a single result
// with zero data and status 1 is given; status 2 marks an overflowed set.
// The walk halts whenever a result waits untaken in the output register, so
// a stalled output lengthens the walk and delays the closing result.
module above_average_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tlast,   // final_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] picked
  output logic        out_tlast,  // end_of_run
  output logic [1:0]  out_tuser   // [1:0] status
);

  aaf_pkg::aaf_cmd_t  cmd;
  aaf_pkg::aaf_stat_t stat;

  aaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aaf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .sample     (in_tdata),
    .picked     (out_tdata),
    .end_of_run (out_tlast),
    .status     (out_tuser),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready)
  );

endmodule

### design/aaf_checker.sv
`timescale 1ns / 1ps

module aaf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // closing a set starts the walk, so input is held off the next cycle
  a_close_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still accepted after set closed");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= aaf_pkg::ST_OVERFLOW))
    else $error("illegal status code");

  a_none_above_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == aaf_pkg::ST_NONE_ABOVE) |-> (out_tlast && out_tdata == 32'd0))
    else $error("nothing-above result must be a lone zero with tlast");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind above_average_filter aaf_checker u_aaf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic signed [31:0] picked;
    logic               end_of_run;
    aaf_pkg::status_t   status;
  } pick_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic signed [31:0] sample;
    logic               closes;
    logic               typed;
    pick_t              want;
  } row_t;

  typedef enum int {FILL_RANDOM, FILL_FLAT, FILL_EXTREME, FILL_NARROW} fill_t;

  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam pick_t NO_PICK = '0;
  localparam int DIR_ROWS     = 20;
  localparam int ITEM_TARGET  = 200;
  localparam int HOLD_AFTER   = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_PCT     = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  above_average_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  row_t dir_rows [DIR_ROWS] = '{
    // single element: nothing strictly above its own mean
    '{32'sd5,  1'b1, 1'b1, '{32'sd0, 1'b1, aaf_pkg::ST_NONE_ABOVE}},
    '{S_MIN,   1'b0, 1'b0, NO_PICK},
    '{S_MAX,   1'b1, 1'b1, '{S_MAX, 1'b1, aaf_pkg::ST_OK}},
    // all equal
    '{-32'sd1, 1'b0, 1'b0, NO_PICK},
    '{-32'sd1, 1'b0, 1'b0, NO_PICK},
    '{-32'sd1, 1'b1, 1'b1, '{32'sd0, 1'b1, aaf_pkg::ST_NONE_ABOVE}},
    '{32'sd0,  1'b0, 1'b0, NO_PICK},
    '{S_MAX,   1'b0, 1'b0, NO_PICK},
    '{S_MAX,   1'b0, 1'b0, NO_PICK},
    '{S_MIN,   1'b1, 1'b0, NO_PICK},
    '{32'sd3,  1'b0, 1'b0, NO_PICK},
    '{-32'sd7, 1'b0, 1'b0, NO_PICK},
    '{32'sd1,  1'b0, 1'b0, NO_PICK},
    '{32'sd10, 1'b0, 1'b0, NO_PICK},
    '{-32'sd2, 1'b1, 1'b0, NO_PICK},
    '{S_MIN,   1'b0, 1'b0, NO_PICK},
    '{S_MIN,   1'b0, 1'b0, NO_PICK},
    '{S_MAX,   1'b1, 1'b0, NO_PICK},
    '{32'sd0,  1'b0, 1'b0, NO_PICK},
    '{32'sd1,  1'b1, 1'b1, '{32'sd1, 1'b1, aaf_pkg::ST_OK}}
  };

  // predictor state
  logic signed [31:0] stored_samples [aaf_pkg::MAX_ELEMENTS];
  longint             sample_sum;
  int                 samples_held;
  bit                 set_overflowed;
  pick_t              close_picks [$];

  pick_t expected_picks [$];
  pick_t oldest_pick;
  int    mismatches  = 0;
  int    items_taken = 0;
  int    cycle_no    = 0;
  int    idle_cycles = 0;
  bit    held_off    = 1'b0;

  // loads one sample; on a closing sample fills close_picks with the results
  task automatic filter_step(input logic signed [31:0] s, input logic closes);
    longint           v;
    aaf_pkg::status_t st;
    int               i;
    close_picks.delete();
    if (samples_held < aaf_pkg::MAX_ELEMENTS) begin
      stored_samples[samples_held] = s;
      sample_sum += s;
      samples_held++;
    end else begin
      set_overflowed = 1'b1;
    end
    if (!closes) return;
    st = set_overflowed ? aaf_pkg::ST_OVERFLOW : aaf_pkg::ST_OK;
    // v * n > sum is the exact form of v > mean
    for (i = 0; i < samples_held; i++) begin
      v = stored_samples[i];
      if (v * samples_held > sample_sum)
        close_picks.push_back('{stored_samples[i], 1'b0, st});
    end
    if (close_picks.size() == 0)
      close_picks.push_back('{32'sd0, 1'b1,
                              set_overflowed ? aaf_pkg::ST_OVERFLOW : aaf_pkg::ST_NONE_ABOVE});
    else
      close_picks[close_picks.size() - 1].end_of_run = 1'b1;
    sample_sum     = 0;
    samples_held   = 0;
    set_overflowed = 1'b0;
  endtask

  function automatic bit calm_window();
    return cycle_no >= 350 && cycle_no < 750;
  endfunction

  task automatic offer(input logic signed [31:0] s, input logic closes, input logic typed,
                       input pick_t want);
    while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= closes;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_taken++;
    filter_step(s, closes);
    if (typed) begin
      expected_picks.push_back(want);
    end else begin
      foreach (close_picks[k]) expected_picks.push_back(close_picks[k]);
    end
  endtask

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_picks.size() == 0) begin
        $display("%0t unexpected transaction: picked %0d last %0b status %0d", $time,
                 $signed(out_tdata), out_tlast, out_tuser);
        mismatches++;
      end else begin
        oldest_pick = expected_picks.pop_front();
        if (out_tdata !== oldest_pick.picked) begin
          $display("%0t mismatch picked: expected %0d, got %0d", $time,
                   oldest_pick.picked, $signed(out_tdata));
          mismatches++;
        end
        if (out_tlast !== oldest_pick.end_of_run) begin
          $display("%0t mismatch end_of_run: expected %0b, got %0b", $time,
                   oldest_pick.end_of_run, out_tlast);
          mismatches++;
        end
        if (out_tuser !== oldest_pick.status) begin
          $display("%0t mismatch status: expected %0d, got %0d", $time,
                   oldest_pick.status, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && items_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int                 set_no;
    int                 set_len;
    int                 k;
    fill_t              fill;
    logic signed [31:0] base;
    logic signed [31:0] s;
    sample_sum     = 0;
    samples_held   = 0;
    set_overflowed = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      offer(dir_rows[r].sample, dir_rows[r].closes, dir_rows[r].typed, dir_rows[r].want);

    set_no = 0;
    while (items_taken < ITEM_TARGET) begin
      // first two sets overrun the buffer: one flat, one random
      if (set_no == 0) begin
        set_len = aaf_pkg::MAX_ELEMENTS + 2;
        fill    = FILL_FLAT;
      end else if (set_no == 1) begin
        set_len = aaf_pkg::MAX_ELEMENTS + 1;
        fill    = FILL_RANDOM;
      end else begin
        if ($urandom_range(0, 15) == 0)
          set_len = $urandom_range(aaf_pkg::MAX_ELEMENTS - 1, aaf_pkg::MAX_ELEMENTS + 3);
        else
          set_len = $urandom_range(1, 10);
        fill = fill_t'($urandom_range(0, 3));
      end
      base = $urandom;
      for (k = 0; k < set_len; k++) begin
        case (fill)
          FILL_FLAT:   s = base;
          FILL_NARROW: s = $signed($urandom_range(0, 8)) - 32'sd4;
          FILL_EXTREME: begin
            case ($urandom_range(0, 3))
              0:       s = S_MIN;
              1:       s = S_MAX;
              2:       s = 32'sd0;
              default: s = -32'sd1;
            endcase
          end
          default:     s = $urandom;
        endcase
        offer(s, k == set_len - 1, 1'b0, NO_PICK);
      end
      set_no++;
    end
    in_tvalid <= 1'b0;

    while (expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
design/aaf_pkg.sv
design/aaf_ctrl.sv
design/aaf_dp.sv
design/above_average_filter.sv
design/aaf_checker.sv
verif/testbench.sv
